// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge.
`define WDVS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define WDVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	`WDVS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/wdvs_pkg.sv -----
package wdvs_pkg;

	// Store depths
	localparam int POSITIONS = 65536;
	localparam int VALUE_IDS = 65536;
	localparam int POS_AW    = $clog2(POSITIONS);
	localparam int ID_AW     = $clog2(VALUE_IDS);

	// Field and state widths
	localparam int FIELD_W = 16;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 64;
	localparam int CNT_W   = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Clearing pass covers the deeper of the two memories
	localparam int CLR_DEPTH = (POSITIONS > VALUE_IDS) ? POSITIONS : VALUE_IDS;
	localparam int CLR_AW    = $clog2(CLR_DEPTH);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SET    = 2'd2,
		OP_LOAD   = 2'd3
	} op_t;

	// Position memory word: window membership and value id
	typedef struct packed {
		logic               in_win;
		logic [FIELD_W-1:0] id;
	} pos_word_t;

	// Id memory word: occurrence count and real value
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [VAL_W-1:0] val;
	} id_word_t;

	localparam int POS_MW = $bits(pos_word_t);
	localparam int ID_MW  = $bits(id_word_t);

	function automatic logic pos_ok(input logic [FIELD_W-1:0] p);
		return 32'(p) < 32'(POSITIONS);
	endfunction

	function automatic logic id_ok(input logic [FIELD_W-1:0] i);
		return 32'(i) < 32'(VALUE_IDS);
	endfunction

	function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] v);
		return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

endpackage

// ----- rtl/window_distinct_value_sum_top.sv -----
// Each beat's position word is read in S_P1. Misuse, ignored items, a set outside the
// window and a table load then go to S_OUT; add and remove pass S_UP or S_DN; a set in
// the window passes S_DN for a valid old id, then S_UP. Count updates are serial
// read-modify-write passes through the id memory. The next beat is taken as the result
// is loaded, once the output slot is free. Reset: arst_n clears control state, then a
// pass over max(POSITIONS, VALUE_IDS) addresses zeroes both memories, in_ready low.
module window_distinct_value_sum_top
	import wdvs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                opcode,
	input  logic [FIELD_W-1:0]        position,
	input  logic [FIELD_W-1:0]        value_id,
	input  logic signed [VAL_W-1:0]   real_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SUM_W-1:0]   distinct_sum,
	output logic                      misuse
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_P1,
		S_UP,
		S_DN,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [CLR_AW-1:0]   clr_q;
	op_t                 op_q;
	logic [FIELD_W-1:0]  pos_q;
	logic [FIELD_W-1:0]  id_q;
	logic [VAL_W-1:0]    val_q;
	logic [FIELD_W-1:0]  tgt_q;
	logic [SUM_W-1:0]    sum_q;
	logic                misuse_q;
	logic                out_valid_q;
	logic [SUM_W-1:0]    dsum_q;
	logic                mis_out_q;

	// Memory ports
	logic                pos_we;
	logic [POS_AW-1:0]   pos_waddr;
	pos_word_t           pos_wdata;
	logic [POS_AW-1:0]   pos_raddr;
	logic [POS_MW-1:0]   pos_ram_rd;
	logic                id_we;
	logic [ID_AW-1:0]    id_waddr;
	id_word_t            id_wdata;
	logic [ID_AW-1:0]    id_raddr;
	logic [ID_MW-1:0]    id_ram_rd;

	// Forwarding of a write that hits the address being read
	logic                pos_hit_s1;
	pos_word_t           pos_fwd_s1;
	logic                id_hit_s1;
	id_word_t            id_fwd_s1;

	pos_word_t           pos_rd;
	id_word_t            id_rd;
	logic                slot_free;
	logic                accept;
	logic                cur_ok;
	logic [VAL_W+1-1:0]  delta;

	wdvs_ram #(.DEPTH(POSITIONS), .WIDTH(POS_MW)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_ram_rd)
	);

	wdvs_ram #(.DEPTH(VALUE_IDS), .WIDTH(ID_MW)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_waddr),
		.wdata (id_wdata),
		.raddr (id_raddr),
		.rdata (id_ram_rd)
	);

	// Handshake
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) || ((state_q == S_OUT) && slot_free);
	assign accept    = in_valid && in_ready;

	// Read data with forwarding
	assign pos_rd = pos_hit_s1 ? pos_fwd_s1 : pos_word_t'(pos_ram_rd);
	assign id_rd  = id_hit_s1 ? id_fwd_s1 : id_word_t'(id_ram_rd);
	assign cur_ok = id_ok(pos_rd.id);
	assign delta  = {val_q[VAL_W-1], val_q} - {id_rd.val[VAL_W-1], id_rd.val};

	// Decode memory accesses per state
	always_comb begin
		pos_raddr = POS_AW'(position);
		pos_we    = 1'b0;
		pos_waddr = POS_AW'(pos_q);
		pos_wdata = '{in_win: 1'b0, id: pos_rd.id};
		id_raddr  = ID_AW'(value_id);
		id_we     = 1'b0;
		id_waddr  = ID_AW'(tgt_q);
		id_wdata  = id_rd;
		case (state_q)
			S_CLEAR: begin
				pos_waddr = POS_AW'(clr_q);
				pos_wdata = '0;
				pos_we    = 32'(clr_q) < 32'(POSITIONS);
				id_waddr  = ID_AW'(clr_q);
				id_wdata  = '0;
				id_we     = 32'(clr_q) < 32'(VALUE_IDS);
			end
			S_P1: begin
				case (op_q)
					OP_ADD: begin
						id_raddr  = ID_AW'(pos_rd.id);
						pos_wdata = '{in_win: 1'b1, id: pos_rd.id};
						pos_we    = pos_ok(pos_q) && !pos_rd.in_win && cur_ok;
					end
					OP_REMOVE: begin
						id_raddr  = ID_AW'(pos_rd.id);
						pos_wdata = '{in_win: 1'b0, id: pos_rd.id};
						pos_we    = pos_ok(pos_q) && pos_rd.in_win && cur_ok;
					end
					OP_SET: begin
						id_raddr  = cur_ok ? ID_AW'(pos_rd.id) : ID_AW'(id_q);
						pos_wdata = '{in_win: pos_rd.in_win, id: id_q};
						pos_we    = pos_ok(pos_q) && id_ok(id_q);
					end
					OP_LOAD: begin
						id_waddr = ID_AW'(id_q);
						id_wdata = '{cnt: id_rd.cnt, val: val_q};
						id_we    = id_ok(id_q);
					end
					default: ;
				endcase
			end
			S_UP: begin
				id_wdata = '{cnt: id_rd.cnt + CNT_W'(1), val: id_rd.val};
				id_we    = id_rd.cnt != CNT_MAX;
			end
			S_DN: begin
				id_raddr = ID_AW'(id_q);
				id_wdata = '{cnt: id_rd.cnt - CNT_W'(1), val: id_rd.val};
				id_we    = id_rd.cnt != '0;
			end
			default: ;
		endcase
	end

	// Track same-address write and read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_hit_s1 <= 1'b0;
			id_hit_s1  <= 1'b0;
		end else begin
			pos_hit_s1 <= pos_we && (pos_waddr == pos_raddr);
			id_hit_s1  <= id_we && (id_waddr == id_raddr);
		end
	end

	always_ff @(posedge clk) begin
		pos_fwd_s1 <= pos_wdata;
		id_fwd_s1  <= id_wdata;
	end

	// Sequencer, running sum and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sum_q       <= '0;
			misuse_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				op_q     <= op_t'(opcode);
				pos_q    <= position;
				id_q     <= value_id;
				val_q    <= real_value;
				misuse_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLR_AW'(1);
					if (clr_q == CLR_AW'(CLR_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_P1;
					end
				end
				S_P1: begin
					state_q <= S_OUT;
					tgt_q   <= pos_rd.id;
					case (op_q)
						OP_ADD: begin
							if (pos_ok(pos_q)) begin
								if (pos_rd.in_win) begin
									misuse_q <= 1'b1;
								end else if (cur_ok) begin
									state_q <= S_UP;
								end
							end
						end
						OP_REMOVE: begin
							if (pos_ok(pos_q)) begin
								if (!pos_rd.in_win) begin
									misuse_q <= 1'b1;
								end else if (cur_ok) begin
									state_q <= S_DN;
								end
							end
						end
						OP_SET: begin
							if (pos_ok(pos_q) && id_ok(id_q) && pos_rd.in_win) begin
								if (cur_ok) begin
									state_q <= S_DN;
								end else begin
									tgt_q   <= id_q;
									state_q <= S_UP;
								end
							end
						end
						OP_LOAD: begin
							if (id_ok(id_q) && (id_rd.cnt != '0)) begin
								sum_q <= sum_q + {{(SUM_W-VAL_W-1){delta[VAL_W]}}, delta};
							end
						end
						default: ;
					endcase
				end
				S_UP: begin
					if (id_rd.cnt == '0) begin
						sum_q <= sum_q + sext_val(id_rd.val);
					end
					state_q <= S_OUT;
				end
				S_DN: begin
					if (id_rd.cnt == CNT_W'(1)) begin
						sum_q <= sum_q - sext_val(id_rd.val);
					end
					// a set continues with the new id's count
					if (op_q == OP_SET) begin
						tgt_q   <= id_q;
						state_q <= S_UP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						dsum_q      <= sum_q;
						mis_out_q   <= misuse_q;
						out_valid_q <= 1'b1;
						state_q     <= accept ? S_P1 : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign distinct_sum = dsum_q;
	assign misuse       = mis_out_q;

endmodule

// ----- rtl/wdvs_ram.sv -----
module wdvs_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/wdvs_checker.sv -----
`include "assert_macros.svh"

module wdvs_checker
	import wdvs_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SUM_W-1:0] distinct_sum,
	input logic             misuse
);

	// Hold a stalled result beat
	`WDVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	`WDVS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(distinct_sum) && $stable(misuse), "result changed under stall")

	// Take no new beat while an item is being worked
	`WDVS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

	// Stay closed to input while the clearing pass runs
	`WDVS_ASSERT_NEXT(a_clear_after_reset, $rose(arst_n), !in_ready, "input open during clearing pass")

endmodule

bind window_distinct_value_sum_top wdvs_checker u_wdvs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.distinct_sum (distinct_sum),
	.misuse       (misuse)
);

// ----- verif/window_distinct_value_sum_top_tb.sv -----
`timescale 1ns / 100ps

module window_distinct_value_sum_top_tb
	import wdvs_pkg::*;
();

	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4 * CLR_DEPTH;
	localparam int PHASE_BEATS   = 425;
	localparam int DIRECTED_ROWS = 22;

	// One expected result beat
	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic                    misuse;
	} sum_beat_t;

	// One row of the directed table; known marks a result typed in by hand
	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] id;
		logic [VAL_W-1:0]   val;
		logic               known;
		logic [SUM_W-1:0]   sum;
		logic               mis;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_REMOVE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 64'd0, 1'b1},
		'{OP_LOAD,   16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 1'b1, 64'd0, 1'b0},
		'{OP_LOAD,   16'h0000, 16'hFFFF, 32'h8000_0000, 1'b1, 64'd0, 1'b0},
		'{OP_SET,    16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, 64'd0, 1'b0},
		'{OP_SET,    16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 64'd0, 1'b0},
		'{OP_ADD,    16'h0000, 16'hFFFF, 32'h8000_0000, 1'b1, 64'd2147483647, 1'b0},
		'{OP_ADD,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 64'd2147483647, 1'b1},
		'{OP_ADD,    16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
		'{OP_LOAD,   16'h0000, 16'h0001, 32'h0000_0005, 1'b0, 64'd0, 1'b0},
		'{OP_SET,    16'hFFFF, 16'h0001, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_SET,    16'h5555, 16'h0000, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_ADD,    16'h5555, 16'h1234, 32'h1234_5678, 1'b0, 64'd0, 1'b0},
		'{OP_LOAD,   16'h0000, 16'h0000, 32'hFFFF_FFF9, 1'b0, 64'd0, 1'b0},
		'{OP_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_REMOVE, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, 64'd0, 1'b0},
		'{OP_REMOVE, 16'h5555, 16'h5555, 32'h5555_5555, 1'b0, 64'd0, 1'b0},
		'{OP_LOAD,   16'h0000, 16'hAAAA, 32'h5555_5555, 1'b0, 64'd0, 1'b0},
		'{OP_SET,    16'hAAAA, 16'hAAAA, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_ADD,    16'hAAAA, 16'h0000, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_SET,    16'hFFFF, 16'h0001, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_REMOVE, 16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
		'{OP_REMOVE, 16'hAAAA, 16'h0000, 32'h0000_0000, 1'b0, 64'd0, 1'b0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                opcode;
	logic [FIELD_W-1:0]        position;
	logic [FIELD_W-1:0]        value_id;
	logic signed [VAL_W-1:0]   real_value;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [SUM_W-1:0]   distinct_sum;
	logic                      misuse;

	// Predictor state: window contents, id counts and the running sum
	bit [FIELD_W-1:0]        pos_id    [POSITIONS];
	bit                      pos_in    [POSITIONS];
	bit                      pos_set   [POSITIONS];
	bit [CNT_W-1:0]          id_cnt    [VALUE_IDS];
	bit signed [VAL_W-1:0]   id_val    [VALUE_IDS];
	bit                      id_loaded [VALUE_IDS];
	bit signed [SUM_W-1:0]   window_sum;
	int                      pos_list [$];
	int                      id_list  [$];

	sum_beat_t pending_sums [$];
	sum_beat_t oldest;
	int        error_count;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        hold_req;
	int        quiet_cycles;

	window_distinct_value_sum_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.position     (position),
		.value_id     (value_id),
		.real_value   (real_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.distinct_sum (distinct_sum),
		.misuse       (misuse)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_mismatch(string what);
		error_count++;
		if (error_count <= 50) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	// Bump an id's count; add its value on the first occurrence
	function automatic void count_up(logic [FIELD_W-1:0] id);
		bit signed [SUM_W-1:0] delta;
		if (id_cnt[id] < CNT_MAX) begin
			id_cnt[id] = id_cnt[id] + CNT_W'(1);
			delta = SUM_W'(id_val[id]);
			if (id_cnt[id] == 1) begin
				window_sum = window_sum + delta;
			end
		end
	endfunction

	// Drop an id's count; subtract its value when the last one leaves
	function automatic void count_down(logic [FIELD_W-1:0] id);
		bit signed [SUM_W-1:0] delta;
		if (id_cnt[id] > 0) begin
			id_cnt[id] = id_cnt[id] - CNT_W'(1);
			delta = SUM_W'(id_val[id]);
			if (id_cnt[id] == 0) begin
				window_sum = window_sum - delta;
			end
		end
	endfunction

	// Apply one beat to the predictor and return the sum it leaves
	function automatic sum_beat_t next_distinct_sum(op_t op, logic [FIELD_W-1:0] pos,
			logic [FIELD_W-1:0] id, logic [VAL_W-1:0] val);
		sum_beat_t             res;
		logic [FIELD_W-1:0]    cur;
		bit signed [SUM_W-1:0] old_v;
		bit signed [SUM_W-1:0] new_v;
		bit                    pos_valid;
		bit                    id_valid;
		res.misuse = 1'b0;
		pos_valid  = int'(pos) < POSITIONS;
		id_valid   = int'(id) < VALUE_IDS;
		case (op)
			OP_ADD: begin
				if (pos_valid) begin
					if (pos_in[pos]) begin
						res.misuse = 1'b1;
					end else begin
						cur = pos_id[pos];
						if (int'(cur) < VALUE_IDS) begin
							pos_in[pos] = 1'b1;
							count_up(cur);
						end
					end
				end
			end
			OP_REMOVE: begin
				if (pos_valid) begin
					if (!pos_in[pos]) begin
						res.misuse = 1'b1;
					end else begin
						cur = pos_id[pos];
						if (int'(cur) < VALUE_IDS) begin
							pos_in[pos] = 1'b0;
							count_down(cur);
						end
					end
				end
			end
			OP_SET: begin
				if (pos_valid && id_valid) begin
					if (!pos_set[pos]) begin
						pos_set[pos] = 1'b1;
						pos_list.push_back(int'(pos));
					end
					// swap the id through the counts when the position is live
					if (pos_in[pos]) begin
						cur = pos_id[pos];
						if (int'(cur) < VALUE_IDS) begin
							count_down(cur);
						end
						pos_id[pos] = id;
						count_up(id);
					end else begin
						pos_id[pos] = id;
					end
				end
			end
			default: begin
				if (id_valid) begin
					if (!id_loaded[id]) begin
						id_loaded[id] = 1'b1;
						id_list.push_back(int'(id));
					end
					// correct the sum when the id is present
					if (id_cnt[id] > 0) begin
						old_v      = SUM_W'(id_val[id]);
						id_val[id] = val;
						new_v      = SUM_W'(id_val[id]);
						window_sum = window_sum - old_v + new_v;
					end else begin
						id_val[id] = val;
					end
				end
			end
		endcase
		res.sum = window_sum;
		return res;
	endfunction

	// Offer one beat, hold it until taken, then predict its result
	task automatic send_beat(op_t op, logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] id,
			logic [VAL_W-1:0] val, output sum_beat_t predicted);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		position   <= pos;
		value_id   <= id;
		real_value <= val;
		do @(posedge clk); while (!in_ready);
		predicted = next_distinct_sum(op, pos, id, val);
	endtask

	// Build a random beat that never reads an unwritten store entry
	task automatic send_random_beat();
		op_t                op;
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] id;
		logic [VAL_W-1:0]   val;
		int                 r;
		sum_beat_t          predicted;
		r  = $urandom_range(99);
		op = (r < 35) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 85) ? OP_SET : OP_LOAD;
		// favor a small hot set of positions so the window churns
		r = $urandom_range(99);
		if (pos_list.size() > 0 && r < 50) begin
			pos = FIELD_W'(pos_list[$urandom_range(
				pos_list.size() < 32 ? pos_list.size() - 1 : 31)]);
		end else if (pos_list.size() > 0 && r < 80) begin
			pos = FIELD_W'(pos_list[$urandom_range(pos_list.size() - 1)]);
		end else begin
			pos = FIELD_W'($urandom_range(65535));
		end
		// favor a few ids so counts climb above one
		r = $urandom_range(99);
		if (id_list.size() > 0 && r < 50) begin
			id = FIELD_W'(id_list[$urandom_range(
				id_list.size() < 16 ? id_list.size() - 1 : 15)]);
		end else if (id_list.size() > 0 && r < 75) begin
			id = FIELD_W'(id_list[$urandom_range(id_list.size() - 1)]);
		end else begin
			id = FIELD_W'($urandom_range(65535));
		end
		val = $urandom();
		// turn an add that would read unwritten data into the write it needs
		if (op == OP_ADD && !pos_in[pos]) begin
			if (!pos_set[pos]) begin
				op = OP_SET;
			end else if (!id_loaded[pos_id[pos]]) begin
				op = OP_LOAD;
				id = pos_id[pos];
			end
		end
		if (op == OP_SET && pos_in[pos] && !id_loaded[id]) begin
			op = OP_LOAD;
		end
		send_beat(op, pos, id, val, predicted);
		pending_sums.push_back(predicted);
	endtask

	task automatic run_phase(int n_beats, int idle_pct, int stall_pct, bit do_hold,
			bit do_drain);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n_beats; k++) begin
			// stall the output for a long stretch while beats keep coming
			if (do_hold && k == n_beats / 2) begin
				hold_req = 1'b1;
			end
			// pause the input until every result is out
			if (do_drain && k == n_beats / 3) begin
				in_valid <= 1'b0;
				wait (pending_sums.size() == 0);
				@(posedge clk);
			end
			send_random_beat();
		end
	endtask

	// Main sequence: reset, directed table, then random phases
	initial begin
		sum_beat_t predicted;
		sum_beat_t known_beat;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		window_sum     = '0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		opcode     <= OP_ADD;
		position   <= '0;
		value_id   <= '0;
		real_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_beat(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].id, DIRECTED[i].val,
				predicted);
			known_beat.sum    = DIRECTED[i].sum;
			known_beat.misuse = DIRECTED[i].mis;
			pending_sums.push_back(DIRECTED[i].known ? known_beat : predicted);
		end

		run_phase(PHASE_BEATS, 0, 0, 1'b1, 1'b0);
		run_phase(PHASE_BEATS, 50, 0, 1'b0, 1'b1);
		run_phase(PHASE_BEATS, 0, 50, 1'b0, 1'b0);
		run_phase(PHASE_BEATS, 28, 28, 1'b1, 1'b1);

		// drain and let the block settle
		in_valid <= 1'b0;
		wait (pending_sums.size() == 0);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Output side: random stalls plus the requested long hold-off
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				flag_mismatch("result beat with nothing expected");
			end else begin
				oldest = pending_sums.pop_front();
				if (distinct_sum !== oldest.sum) begin
					flag_mismatch($sformatf("distinct_sum %0d, expected %0d",
						distinct_sum, oldest.sum));
				end
				if (misuse !== oldest.misuse) begin
					flag_mismatch($sformatf("misuse %0b, expected %0b",
						misuse, oldest.misuse));
				end
			end
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
